// File: rtl/tdpt_pkg.sv
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } tdpt_state_e;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } tdpt_div_stat_t;

endpackage

// File: rtl/tdpt_div.sv
module tdpt_div #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [NUM_WIDTH-1:0]    dividend_i,
  input  logic [NUM_WIDTH-1:0]    divisor_i,
  output logic [NUM_WIDTH-1:0]    quotient_o,
  output tdpt_pkg::tdpt_div_stat_t stat_o
);

  localparam int CntW = $clog2(NUM_WIDTH);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [NUM_WIDTH-1:0] dvd_q, dvd_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] dsr_q, dsr_d;
  logic [NUM_WIDTH:0]   rem_sh;
  logic                 ge;

  // One quotient bit per cycle, restoring style.
  always_comb begin
    rem_sh = {rem_q, dvd_q[NUM_WIDTH-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NUM_WIDTH - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NUM_WIDTH-2:0], ge};
      if (ge) begin
        rem_d = NUM_WIDTH'(rem_sh - {1'b0, dsr_q});
      end else begin
        rem_d = rem_sh[NUM_WIDTH-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o      = dvd_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

// File: rtl/trial_division_predecessor_test.sv
// Tests whether n-1 is composite by trial division, with n on number_in_i; n below 3 and
// n equal to 4 give 0, n equal to 3 gives 1. One transaction is handled at a time. Values
// settled without dividing (n up to 4, or n-1 even) go straight to the output hold state.
// Otherwise m = n-1 is divided by the odd candidates 3, 5, 7, ... up to sqrt(m), each by
// a bit-serial divider. A new transaction is accepted while a result waits.
module trial_division_predecessor_test #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [NUM_WIDTH-1:0] number_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_divisor_o
);

  tdpt_pkg::tdpt_state_e    state_q, state_d;
  tdpt_pkg::tdpt_div_stat_t div_stat;
  logic [NUM_WIDTH-1:0]     quotient;
  logic [NUM_WIDTH-1:0]     m_q, m_d;
  logic [NUM_WIDTH-1:0]     d_q, d_d;
  logic                     res_q, res_d;
  logic                     start_q, start_d;
  logic                     out_valid_q, out_valid_d;
  logic                     found_q, found_d;

  tdpt_div #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .dividend_i(m_q),
    .divisor_i (d_q),
    .quotient_o(quotient),
    .stat_o    (div_stat)
  );

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    d_d         = d_q;
    res_d       = res_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          m_d = number_in_i - NUM_WIDTH'(1);
          d_d = NUM_WIDTH'(3);
          if (number_in_i < NUM_WIDTH'(3)) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_HOLD;
          end else if (number_in_i == NUM_WIDTH'(3)) begin
            res_d   = 1'b1;
            state_d = tdpt_pkg::ST_HOLD;
          end else if (number_in_i == NUM_WIDTH'(4)) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_HOLD;
          end else if (number_in_i[0]) begin
            res_d   = 1'b1;
            state_d = tdpt_pkg::ST_HOLD;
          end else begin
            start_d = 1'b1;
            state_d = tdpt_pkg::ST_DIV;
          end
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (quotient < d_q) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_HOLD;
          end else if (div_stat.rem_zero) begin
            res_d   = 1'b1;
            state_d = tdpt_pkg::ST_HOLD;
          end else begin
            d_d     = d_q + NUM_WIDTH'(2);
            start_d = 1'b1;
          end
        end
      end
      tdpt_pkg::ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = res_q;
          state_d     = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    d_q     <= d_d;
    res_q   <= res_d;
    found_q <= found_d;
  end

  assign in_ready_o      = (state_q == tdpt_pkg::ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign found_divisor_o = found_q;

endmodule

// File: rtl/tdpt_chk.sv
module tdpt_chk #(
  parameter int NUM_WIDTH = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [NUM_WIDTH-1:0] number_in_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 found_divisor_o
);

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(number_in_i)))
    else $error("waiting input changed or dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(found_divisor_o)))
    else $error("stalled result changed or dropped");

  // A new result is only produced after the block has been busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a transaction in flight");

endmodule

bind trial_division_predecessor_test tdpt_chk #(
  .NUM_WIDTH(NUM_WIDTH)
) u_tdpt_chk (.*);
